>>> sv/cma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared constants, register map and window helper for the centered moving average
// no dependencies

package cma_pkg;

  localparam int unsigned MaxWindowDef  = 127;
  localparam int unsigned SampleBitsDef = 16;

  // fixed payload widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgW    = 7;

  // apb register map
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned RegIdxW  = PaddrW - 2;
  localparam logic [RegIdxW-1:0] RegWindowLength = RegIdxW'(0);

  localparam int unsigned WinReset = 11;

  // requested length -> odd length, limited to max_w, zero taken as one
  function automatic int unsigned eff_window(int unsigned v, int unsigned max_w);
    int unsigned m;
    m = (v > max_w) ? max_w : v;
    if ((m & 32'd1) == 32'd0) begin
      m = (m == 32'd0) ? 32'd1 : m - 32'd1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> sv/cma_if.sv
`timescale 1ns / 1ps
`default_nettype none
// valid/ready channels for samples in and smoothed results out
// depends on cma_pkg

interface cma_in_if;
  import cma_pkg::*;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;
  logic               is_final;

  modport source (output valid, sample, is_final, input ready);
  modport sink (input valid, sample, is_final, output ready);
endinterface

interface cma_out_if;
  import cma_pkg::*;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] smoothed;
  logic               averaged;
  logic               end_of_series;

  modport source (output valid, smoothed, averaged, end_of_series, input ready);
  modport sink (input valid, smoothed, averaged, end_of_series, output ready);
endinterface

`default_nettype wire

>>> sv/centered_moving_average_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Centered moving average over an odd window on a sample stream ended by is_final.
// Samples arrive on in_i, results leave on out_o (valid/ready, request taken when
// both are high). The window length register sits at apb address 0.
// Each sample does a read-modify-write of the delay ring (registered read)
// and updates the running window sum. Interior positions are averaged by a
// multiply with a reciprocal of the window length picked when the register is written.
// A sample that yields an average lets the next request be taken while its
// result is loaded; one that yields a raw edge sample, fetched by a ring read
// of the delayed entry, returns to idle before the next request is taken.
// A final sample flushes its raw tail entries, each one a ring read, and the
// block then returns to idle before the next request.
// An average passes through StSum and StAvg into the output register.
// A stalled receiver holds the result in the output register; the next request is
// still taken and summed, then the block waits until the output frees.
// Reset clears the series state and sets window length 11; the ring needs no clear.
// Writing the window length drops the current series without results.
// Depends on cma_pkg and cma_if.

module centered_moving_average_core #(
  parameter int unsigned MaxWindow  = cma_pkg::MaxWindowDef,
  parameter int unsigned SampleBits = cma_pkg::SampleBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  cma_in_if.sink                          in_i,
  cma_out_if.source                       out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cma_pkg::PaddrW-1:0]      paddr,
  input  logic [cma_pkg::ApbDataW-1:0]    pwdata,
  output logic [cma_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);
  import cma_pkg::*;

  localparam int unsigned WinW   = $clog2(MaxWindow + 1);
  localparam int unsigned DataW  = (SampleBits < SampleW) ? SampleBits : SampleW;
  localparam int unsigned SumW   = DataW + WinW;
  localparam int unsigned ShiftK = SumW + WinW;
  localparam int unsigned RecipW = ShiftK + 1;
  localparam int unsigned ProdW  = SumW + RecipW;
  localparam int unsigned Depth  = 2 ** WinW;
  localparam int unsigned ResetWin = eff_window(WinReset, MaxWindow);
  localparam longint unsigned ResetRecip =
    ((64'd1 << ShiftK) + longint'(ResetWin) - 64'd1) / longint'(ResetWin);

  typedef enum logic [2:0] {StIdle, StSum, StRaw, StAvg, StFlush} state_e;

  state_e              state_q;
  logic [CfgW-1:0]     wl_q;
  logic [WinW-1:0]     m_q;
  logic [RecipW-1:0]   recip_q;
  logic [WinW-1:0]     count_q;
  logic [SumW-1:0]     sum_q;
  logic [WinW-1:0]     ptr_q;
  logic [WinW-1:0]     base_q;
  logic [WinW-1:0]     flush_q;
  logic [DataW-1:0]    s_q;
  logic                fin_q;
  logic                end_q;
  logic [SumW-1:0]     sumout_q;
  logic                out_valid_q;
  logic [SampleW-1:0]  smoothed_q;
  logic                averaged_q;
  logic                eos_q;

  // delay ring
  logic [DataW-1:0]    ring [Depth];
  logic [DataW-1:0]    mem_q;
  logic                fwd_q;
  logic                rd_en;
  logic [WinW-1:0]     rd_addr;
  logic                we;
  logic [DataW-1:0]    rd_data;

  logic                apb_wr;
  logic                cfg_we;
  logic [WinW-1:0]     cfg_eff;
  logic [RecipW-1:0]   recip_tab [Depth];
  logic [WinW-1:0]     half;
  logic                out_free;
  logic                out_load;
  logic                in_ready;
  logic                accept;
  logic [SumW-1:0]     sum_new;
  logic [WinW-1:0]     cnt_new;
  logic [WinW-1:0]     flush_new;
  logic [ProdW-1:0]    prod;
  logic [DataW-1:0]    quot;

  // reciprocal table, ceil(2^K / m), exact floor division for sums below 2^SumW
  for (genvar g = 0; g < Depth; g++) begin : g_recip
    localparam longint unsigned Div = (g == 0) ? 64'd1 : longint'(g);
    localparam longint unsigned Rcp = ((64'd1 << ShiftK) + Div - 64'd1) / Div;
    assign recip_tab[g] = RecipW'(Rcp);
  end

  assign apb_wr  = psel & penable & pwrite;
  assign cfg_we  = apb_wr && (paddr[PaddrW-1:2] == RegWindowLength);
  assign cfg_eff = WinW'(eff_window(32'(pwdata[CfgW-1:0]), MaxWindow));
  assign pready  = 1'b1;
  assign prdata  = (paddr[PaddrW-1:2] == RegWindowLength) ? ApbDataW'(wl_q) : '0;

  assign half     = m_q >> 1;
  assign out_free = !out_valid_q || out_o.ready;
  assign out_load = ((state_q == StRaw) || (state_q == StAvg) || (state_q == StFlush)) &&
                    out_free;
  assign in_ready = (state_q == StIdle) ||
                    ((state_q == StAvg) && out_free && (flush_q == '0));
  assign accept   = in_i.valid && in_ready;
  assign rd_data  = fwd_q ? s_q : mem_q;
  assign we       = (state_q == StSum);

  assign sum_new = sum_q - ((count_q >= m_q) ? SumW'(rd_data) : '0) + SumW'(s_q);
  assign cnt_new = (count_q < m_q) ? count_q + 1'b1 : m_q;
  assign flush_new = fin_q ? ((cnt_new < half) ? cnt_new : half) : '0;

  assign prod = ProdW'(sumout_q) * ProdW'(recip_q);
  assign quot = prod[ShiftK +: DataW];

  // ring read address
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (accept) begin
      rd_en   = 1'b1;
      rd_addr = ptr_q - m_q;
    end else begin
      unique case (state_q)
        StSum: begin
          if (cnt_new < m_q) begin
            if (cnt_new > half) begin
              rd_en   = 1'b1;
              rd_addr = ptr_q - half;
            end else if (flush_new != '0) begin
              rd_en   = 1'b1;
              rd_addr = ptr_q - (flush_new - 1'b1);
            end
          end
        end
        StRaw, StAvg: begin
          if (out_free && (flush_q != '0)) begin
            rd_en   = 1'b1;
            rd_addr = base_q - (flush_q - 1'b1);
          end
        end
        StFlush: begin
          if (out_free && (flush_q > WinW'(1))) begin
            rd_en   = 1'b1;
            rd_addr = base_q - (flush_q - 2'd2);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      ring[ptr_q] <= s_q;
    end
    if (rd_en) begin
      mem_q <= ring[rd_addr];
    end
  end

  // newest entry read in the cycle it is written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en) begin
      fwd_q <= we && (rd_addr == ptr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wl_q        <= CfgW'(WinReset);
      m_q         <= WinW'(ResetWin);
      recip_q     <= RecipW'(ResetRecip);
      count_q     <= '0;
      sum_q       <= '0;
      ptr_q       <= '0;
      base_q      <= '0;
      flush_q     <= '0;
      s_q         <= '0;
      fin_q       <= 1'b0;
      end_q       <= 1'b0;
      sumout_q    <= '0;
      out_valid_q <= 1'b0;
      smoothed_q  <= '0;
      averaged_q  <= 1'b0;
      eos_q       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we) begin
        wl_q    <= pwdata[CfgW-1:0];
        m_q     <= cfg_eff;
        recip_q <= recip_tab[cfg_eff];
        count_q <= '0;
        sum_q   <= '0;
        ptr_q   <= '0;
      end
      if (accept) begin
        s_q   <= in_i.sample[DataW-1:0];
        fin_q <= in_i.is_final;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= StSum;
          end
        end
        StSum: begin
          sumout_q <= sum_new;
          base_q   <= ptr_q;
          flush_q  <= flush_new;
          end_q    <= fin_q && (flush_new == '0);
          if (fin_q) begin
            sum_q   <= '0;
            count_q <= '0;
            ptr_q   <= '0;
          end else begin
            sum_q   <= sum_new;
            count_q <= cnt_new;
            ptr_q   <= ptr_q + 1'b1;
          end
          if (cnt_new >= m_q) begin
            state_q <= StAvg;
          end else if (cnt_new > half) begin
            state_q <= StRaw;
          end else if (flush_new != '0) begin
            state_q <= StFlush;
          end else begin
            state_q <= StIdle;
          end
        end
        StRaw, StAvg: begin
          if (out_free) begin
            smoothed_q  <= (state_q == StAvg) ? SampleW'(quot) : SampleW'(rd_data);
            averaged_q  <= (state_q == StAvg);
            eos_q       <= end_q;
            if (flush_q != '0) begin
              state_q <= StFlush;
            end else if (accept) begin
              state_q <= StSum;
            end else begin
              state_q <= StIdle;
            end
          end
        end
        StFlush: begin
          if (out_free) begin
            smoothed_q  <= SampleW'(rd_data);
            averaged_q  <= 1'b0;
            eos_q       <= (flush_q == WinW'(1));
            if (flush_q > WinW'(1)) begin
              flush_q <= flush_q - 1'b1;
            end else begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.smoothed      = smoothed_q;
  assign out_o.averaged      = averaged_q;
  assign out_o.end_of_series = eos_q;

  a_count_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= m_q)
    else $error("sample count above window length");

  a_flush_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFlush) |-> (flush_q != '0))
    else $error("tail flush with nothing left");

  a_series_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSum && fin_q) |=> (count_q == '0 && sum_q == '0 && ptr_q == '0))
    else $error("series state not cleared after final sample");

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// testbench for centered_moving_average_core: samples in, smoothed results checked in order
// against a local prediction of the window sums. Depends on cma_pkg, cma_if and the core.

module tb;
  import cma_pkg::*;

  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned ItemTarget  = 480;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned CycleLimit  = 6000000;

  typedef struct packed {
    logic [SampleW-1:0] smoothed;
    logic               averaged;
    logic               end_of_series;
  } smooth_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  cma_in_if  in_ch ();
  cma_out_if out_ch ();

  centered_moving_average_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // predicted block state
  logic [SampleW-1:0] hist_ring [128];
  int unsigned        run_sum;
  int unsigned        fill_count;
  int unsigned        head_idx;
  logic [CfgW-1:0]    win_reg;

  smooth_t smooth_queue[$];

  int unsigned samples_sent;
  int unsigned series_closed;
  int unsigned window_writes;
  int unsigned avg_seen;
  int unsigned raw_seen;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          calm;

  function automatic int unsigned taps();
    int unsigned m;
    m = win_reg;
    if (m > MaxWindowDef) m = MaxWindowDef;
    if (m % 2 == 0) m = (m == 0) ? 1 : m - 1;
    return m;
  endfunction

  function automatic void restart_series();
    run_sum    = 0;
    fill_count = 0;
    head_idx   = 0;
  endfunction

  // append one expected result at the tail
  function automatic void queue_result(input smooth_t r);
    smooth_queue.insert(smooth_queue.size(), r);
  endfunction

  function automatic void predict_outputs(input logic [SampleW-1:0] value, input bit last);
    int unsigned m;
    int unsigned half;
    int unsigned ptr;
    int unsigned tail;
    bit          closes;
    m    = taps();
    half = m / 2;
    ptr  = head_idx;
    if (fill_count >= m) run_sum -= hist_ring[(ptr - m) & 32'd127];
    hist_ring[ptr] = value;
    run_sum += value;
    if (fill_count < m) fill_count++;
    tail   = last ? ((fill_count < half) ? fill_count : half) : 0;
    closes = last && (tail == 0);
    if (fill_count >= m) begin
      queue_result(smooth_t'{SampleW'(run_sum / m), 1'b1, closes});
    end else if (fill_count > half) begin
      queue_result(smooth_t'{hist_ring[(ptr - half) & 32'd127], 1'b0, closes});
    end
    // raw tail, oldest first
    for (int unsigned j = tail; j > 0; j--) begin
      queue_result(smooth_t'{hist_ring[(ptr - (j - 1)) & 32'd127], 1'b0, j == 1});
    end
    head_idx = (ptr + 1) & 32'd127;
    if (last) begin
      restart_series();
      series_closed++;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SampleW-1:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return SampleW'($urandom);
  endfunction

  function automatic int unsigned pick_length(input int unsigned m);
    if (m > 48) begin
      if ($urandom_range(0, 1) == 0) return $urandom_range(1, 20);
      return $urandom_range(m - 2, m + 6);
    end
    return $urandom_range(1, 3 * m + 2);
  endfunction

  // receiver side: random stalls, no new ones while calm
  always @(negedge clk_i) begin
    int unsigned r;
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        out_ch.ready <= 1'b1;
      end else if (r < 95) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    smooth_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (smooth_queue.size() == 0) begin
        $error("unexpected result: smoothed %0d averaged %0b end_of_series %0b",
               out_ch.smoothed, out_ch.averaged, out_ch.end_of_series);
        mismatches++;
      end else begin
        want = smooth_queue.pop_front();
        if (want.averaged) avg_seen++;
        else raw_seen++;
        if (out_ch.smoothed !== want.smoothed) begin
          $error("smoothed: expected %0d, got %0d", want.smoothed, out_ch.smoothed);
          mismatches++;
        end
        if (out_ch.averaged !== want.averaged) begin
          $error("averaged: expected %0b, got %0b", want.averaged, out_ch.averaged);
          mismatches++;
        end
        if (out_ch.end_of_series !== want.end_of_series) begin
          $error("end_of_series: expected %0b, got %0b", want.end_of_series,
                 out_ch.end_of_series);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               smooth_queue.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_sample(input logic [SampleW-1:0] value, input bit last);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.sample   <= value;
    in_ch.is_final <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_outputs(value, last);
    samples_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (smooth_queue.size() != 0) @(posedge clk_i);
  endtask

  // samples that yield nothing may still be in flight once the queue is empty
  task automatic wait_drain();
    hold_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [CfgW-1:0] value,
                            output logic [ApbDataW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {RegWindowLength, 2'b00};
    pwdata  <= ApbDataW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_window_reg(input logic [CfgW-1:0] want);
    logic [ApbDataW-1:0] rdata;
    apb_access(1'b0, '0, rdata);
    if (rdata[CfgW-1:0] !== want) begin
      $error("window_length: expected %0d, got %0d", want, rdata[CfgW-1:0]);
      mismatches++;
    end
  endtask

  // a write drops any open series without results
  task automatic write_window(input logic [CfgW-1:0] value);
    logic [ApbDataW-1:0] rdata;
    wait_drain();
    apb_access(1'b1, value, rdata);
    win_reg = value;
    restart_series();
    window_writes++;
    check_window_reg(value);
  endtask

  task automatic run_series(input int unsigned len, input bit closed);
    int pause_at;
    pause_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, len - 1)) : -1;
    for (int unsigned i = 0; i < len; i++) begin
      if (int'(i) == pause_at) hold_until_drained();
      send_sample(rand_sample(), closed && (i == len - 1));
    end
  endtask

  task automatic test_after_reset();
    check_window_reg(CfgW'(WinReset));
    send_sample('0, 1'b0);
    for (int i = 0; i < 11; i++) send_sample('1, i == 10);
  endtask

  task automatic test_short_series();
    send_sample(16'h1234, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hfffe, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hffff, 1'b1);
  endtask

  task automatic test_window_one();
    write_window(CfgW'(1));
    send_sample(16'hffff, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h5a5a, 1'b1);
  endtask

  task automatic test_window_extremes();
    write_window(CfgW'(0));
    run_series(4, 1'b1);
    write_window(CfgW'(2));
    run_series(5, 1'b1);
    write_window(CfgW'(3));
    run_series(6, 1'b1);
    write_window(CfgW'(4));
    run_series(7, 1'b1);
    write_window(CfgW'(126));
    run_series(40, 1'b1);
    write_window(CfgW'(127));
    run_series(130, 1'b1);
    run_series(20, 1'b1);
  endtask

  task automatic test_dropped_series();
    write_window(CfgW'(5));
    run_series(7, 1'b0);
    hold_until_drained();
    write_window(CfgW'(5));
    run_series(8, 1'b1);
  endtask

  task automatic test_random_series();
    int unsigned r;
    int unsigned req;
    int unsigned groups;
    int unsigned len;
    bit          broken;
    while (samples_sent < ItemTarget) begin
      r = $urandom_range(0, 99);
      if (r < 70) req = $urandom_range(1, 15);
      else if (r < 90) req = $urandom_range(16, 48);
      else req = $urandom_range(0, 127);
      write_window(CfgW'(req));
      groups = $urandom_range(1, 3);
      for (int unsigned g = 0; (g < groups) && (samples_sent < ItemTarget); g++) begin
        calm   = ($urandom_range(0, 3) == 0);
        broken = (g == groups - 1) && ($urandom_range(0, 9) == 0);
        len    = pick_length(taps());
        // keep the total close to the target
        if (len > ItemTarget - samples_sent) len = ItemTarget - samples_sent;
        run_series(len, !broken);
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.sample   = '0;
    in_ch.is_final = 1'b0;
    out_ch.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    for (int i = 0; i < 128; i++) hist_ring[i] = '0;
    win_reg        = CfgW'(WinReset);
    restart_series();
    samples_sent   = 0;
    series_closed  = 0;
    window_writes  = 0;
    avg_seen       = 0;
    raw_seen       = 0;
    mismatches     = 0;
    cycle_count    = 0;
    stall_left     = 0;
    calm           = 1'b0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_after_reset();
    test_short_series();
    test_window_one();
    test_window_extremes();
    test_dropped_series();
    test_random_series();
    wait_drain();

    $display("ran %0d samples, %0d closed series, %0d window register writes",
             samples_sent, series_closed, window_writes);
    $display("compared %0d window averages and %0d raw edge samples", avg_seen, raw_seen);
    if (mismatches == 0 && smooth_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/cma_pkg.sv
sv/cma_if.sv
sv/centered_moving_average_core.sv
sim/tb.sv
